/* hw/rtl/csc_pkg.sv */
// shared widths, register indexes, reset values and arctangent table for the cordic block
package csc_pkg;

    localparam int PHASE_W     = 20;
    localparam int OUT_W       = 19;
    localparam int AMP_W       = 17;
    localparam int ITER_W      = 5;
    localparam int ANGLE_W     = 21;
    localparam int TABLE_LEN   = 18;
    localparam int IDX_W       = 2;

    localparam int MAX_STEPS_DEF  = 18;
    localparam int GUARD_BITS_DEF = 2;

    localparam logic [IDX_W-1:0] REG_AMPLITUDE       = 2'd0;
    localparam logic [IDX_W-1:0] REG_ITERATION_COUNT = 2'd1;

    localparam logic [AMP_W-1:0]  AMPLITUDE_RST       = 17'd79593;
    localparam logic [ITER_W-1:0] ITERATION_COUNT_RST = 5'd18;

    localparam logic signed [ANGLE_W-1:0] PHASE_LIMIT = 21'sh40000;

    localparam logic signed [ANGLE_W-1:0] ARCTAN_TABLE [TABLE_LEN] = '{
        21'sh20000, 21'sh12e40, 21'sh09fb4, 21'sh05111, 21'sh028b1, 21'sh0145d,
        21'sh00a2f, 21'sh00518, 21'sh0028c, 21'sh00146, 21'sh000a3, 21'sh00051,
        21'sh00029, 21'sh00014, 21'sh0000a, 21'sh00005, 21'sh00003, 21'sh00001
    };

endpackage

/* hw/rtl/csc_stage.sv */
// one cordic micro-rotation stage with its pipeline register
module csc_stage #(
    parameter int STAGE  = 0,
    parameter int DATA_W = 21
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic [csc_pkg::ITER_W-1:0]          in_steps,
    input  logic signed [DATA_W-1:0]            in_x,
    input  logic signed [DATA_W-1:0]            in_y,
    input  logic signed [csc_pkg::ANGLE_W-1:0]  in_a,
    output logic                                out_valid,
    output logic [csc_pkg::ITER_W-1:0]          out_steps,
    output logic signed [DATA_W-1:0]            out_x,
    output logic signed [DATA_W-1:0]            out_y,
    output logic signed [csc_pkg::ANGLE_W-1:0]  out_a
);

    localparam logic [csc_pkg::ITER_W-1:0] STAGE_IDX = csc_pkg::ITER_W'(STAGE);
    localparam logic signed [csc_pkg::ANGLE_W-1:0] ATAN = csc_pkg::ARCTAN_TABLE[STAGE];

    logic                                valid_reg;
    logic [csc_pkg::ITER_W-1:0]          steps_reg;
    logic signed [DATA_W-1:0]            x_reg;
    logic signed [DATA_W-1:0]            y_reg;
    logic signed [csc_pkg::ANGLE_W-1:0]  a_reg;
    logic signed [DATA_W-1:0]            x_next;
    logic signed [DATA_W-1:0]            y_next;
    logic signed [csc_pkg::ANGLE_W-1:0]  a_next;
    logic signed [DATA_W-1:0]            dx;
    logic signed [DATA_W-1:0]            dy;

    always_comb
    begin
        dx = in_y >>> STAGE;
        dy = in_x >>> STAGE;
        x_next = in_x;
        y_next = in_y;
        a_next = in_a;
        if (in_steps > STAGE_IDX)
        begin
            if (!in_a[csc_pkg::ANGLE_W-1])
            begin
                x_next = in_x - dx;
                y_next = in_y + dy;
                a_next = in_a - ATAN;
            end
            else
            begin
                x_next = in_x + dx;
                y_next = in_y - dy;
                a_next = in_a + ATAN;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        steps_reg <= in_steps;
        x_reg     <= x_next;
        y_reg     <= y_next;
        a_reg     <= a_next;
    end

    assign out_valid = valid_reg;
    assign out_steps = steps_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_a     = a_reg;

endmodule

/* hw/rtl/cordic_sine_cosine_top.sv */
// pipelined rotation-mode cordic sine and cosine generator, top level
//
//  channel   handshake            payload
//  request   start / busy         phase
//  result    done (one cycle)     cosine, sine
//  config    wr_en                wr_index, wr_data
//
// one request per clock; busy is never raised
// a result passes the input register, one register per micro-rotation and
// the output register; results cannot be held off
// iteration_count selects how many stages rotate, the rest pass data through
// rst_n clears the valid bits and presets the two config registers
module cordic_sine_cosine_top #(
    parameter int MAX_STEPS  = csc_pkg::MAX_STEPS_DEF,
    parameter int GUARD_BITS = csc_pkg::GUARD_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [csc_pkg::PHASE_W-1:0]  phase,
    output logic                                done,
    output logic signed [csc_pkg::OUT_W-1:0]    cosine,
    output logic signed [csc_pkg::OUT_W-1:0]    sine,
    input  logic                                wr_en,
    input  logic [csc_pkg::IDX_W-1:0]           wr_index,
    input  logic [csc_pkg::AMP_W-1:0]           wr_data
);

    localparam int DATA_W = csc_pkg::AMP_W + GUARD_BITS + 2;

    logic [csc_pkg::AMP_W-1:0]          amplitude_reg;
    logic [csc_pkg::ITER_W-1:0]         iteration_count_reg;

    logic signed [csc_pkg::ANGLE_W-1:0] phase_ext;
    logic signed [csc_pkg::ANGLE_W-1:0] phase_sat;

    logic                               v_s     [MAX_STEPS+1];
    logic [csc_pkg::ITER_W-1:0]         steps_s [MAX_STEPS+1];
    logic signed [DATA_W-1:0]           x_s     [MAX_STEPS+1];
    logic signed [DATA_W-1:0]           y_s     [MAX_STEPS+1];
    logic signed [csc_pkg::ANGLE_W-1:0] a_s     [MAX_STEPS+1];

    logic                               in_valid_reg;
    logic [csc_pkg::ITER_W-1:0]         in_steps_reg;
    logic signed [DATA_W-1:0]           in_x_reg;
    logic signed [csc_pkg::ANGLE_W-1:0] in_a_reg;

    logic                               done_reg;
    logic signed [csc_pkg::OUT_W-1:0]   cosine_reg;
    logic signed [csc_pkg::OUT_W-1:0]   sine_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            amplitude_reg       <= csc_pkg::AMPLITUDE_RST;
            iteration_count_reg <= csc_pkg::ITERATION_COUNT_RST;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                csc_pkg::REG_AMPLITUDE:
                    amplitude_reg <= wr_data;
                csc_pkg::REG_ITERATION_COUNT:
                    iteration_count_reg <= wr_data[csc_pkg::ITER_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // phase saturation to plus or minus ninety degrees
    always_comb
    begin
        phase_ext = csc_pkg::ANGLE_W'(phase);
        if (phase_ext > csc_pkg::PHASE_LIMIT)
        begin
            phase_sat = csc_pkg::PHASE_LIMIT;
        end
        else if (phase_ext < -csc_pkg::PHASE_LIMIT)
        begin
            phase_sat = -csc_pkg::PHASE_LIMIT;
        end
        else
        begin
            phase_sat = phase_ext;
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        in_steps_reg <= iteration_count_reg;
        in_x_reg     <= DATA_W'({2'b00, amplitude_reg}) <<< GUARD_BITS;
        in_a_reg     <= phase_sat;
    end

    assign v_s[0]     = in_valid_reg;
    assign steps_s[0] = in_steps_reg;
    assign x_s[0]     = in_x_reg;
    assign y_s[0]     = '0;
    assign a_s[0]     = in_a_reg;

    for (genvar g = 0; g < MAX_STEPS; g++)
    begin : g_stage
        csc_stage #(
            .STAGE  (g),
            .DATA_W (DATA_W)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (v_s[g]),
            .in_steps  (steps_s[g]),
            .in_x      (x_s[g]),
            .in_y      (y_s[g]),
            .in_a      (a_s[g]),
            .out_valid (v_s[g+1]),
            .out_steps (steps_s[g+1]),
            .out_x     (x_s[g+1]),
            .out_y     (y_s[g+1]),
            .out_a     (a_s[g+1])
        );
    end

    // output register, guard bits dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= v_s[MAX_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        cosine_reg <= x_s[MAX_STEPS][GUARD_BITS +: csc_pkg::OUT_W];
        sine_reg   <= y_s[MAX_STEPS][GUARD_BITS +: csc_pkg::OUT_W];
    end

    assign busy   = 1'b0;
    assign done   = done_reg;
    assign cosine = cosine_reg;
    assign sine   = sine_reg;

endmodule
